// ===== sv/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, character codes and match tables for the tag and script
// stripper.
// ----------------------------------------------------------------------------
package hts_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_TAG    = 2'd1,
      MODE_SCRIPT = 2'd2
   } mode_type;

   // entity indexes, in priority order
   localparam logic [1:0] ENT_LT   = 2'd0;
   localparam logic [1:0] ENT_GT   = 2'd1;
   localparam logic [1:0] ENT_AMP  = 2'd2;
   localparam logic [1:0] ENT_NBSP = 2'd3;

   localparam int MAX_OUT = 8;
   localparam int COUNT_W = $clog2(MAX_OUT + 1);

   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_LT  = 8'h3C;
   localparam logic [7:0] CH_GT  = 8'h3E;
   localparam logic [7:0] CH_AMP = 8'h26;
   localparam logic [7:0] CH_S_UP = 8'h53;
   localparam logic [7:0] CH_S_LO = 8'h73;

   typedef struct packed {
      mode_type   text_mode;
      logic [2:0] open_cnt;
      logic       upper;
      logic [3:0] close_cnt;
      logic [2:0] ent_cnt;
      logic [3:0] ent_cand;
      logic       pending_cr;
      logic       line_out;
   } state_type;

   localparam state_type STATE_RESET = '{
      text_mode:  MODE_NORMAL,
      open_cnt:   3'd0,
      upper:      1'b0,
      close_cnt:  4'd0,
      ent_cnt:    3'd0,
      ent_cand:   4'hF,
      pending_cr: 1'b0,
      line_out:   1'b0
   };

   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] bytes;
      logic [COUNT_W-1:0]      count;
   } result_type;

   function automatic logic [7:0] open_pat_byte(input logic upper, input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = "<";
         3'd1:    b = upper ? "S" : "s";
         3'd2:    b = upper ? "C" : "c";
         3'd3:    b = upper ? "R" : "r";
         3'd4:    b = upper ? "I" : "i";
         3'd5:    b = upper ? "P" : "p";
         3'd6:    b = upper ? "T" : "t";
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] close_pat_byte(input logic upper, input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = "<";
         4'd1:    b = "/";
         4'd2:    b = upper ? "S" : "s";
         4'd3:    b = upper ? "C" : "c";
         4'd4:    b = upper ? "R" : "r";
         4'd5:    b = upper ? "I" : "i";
         4'd6:    b = upper ? "P" : "p";
         4'd7:    b = upper ? "T" : "t";
         4'd8:    b = ">";
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] ent_pat_byte(input logic [1:0] sel, input logic [2:0] idx);
      logic [7:0] b;
      b = 8'd0;
      case (sel)
         ENT_LT: begin
            case (idx)
               3'd0:    b = "&";
               3'd1:    b = "l";
               3'd2:    b = "t";
               3'd3:    b = ";";
               default: b = 8'd0;
            endcase
         end
         ENT_GT: begin
            case (idx)
               3'd0:    b = "&";
               3'd1:    b = "g";
               3'd2:    b = "t";
               3'd3:    b = ";";
               default: b = 8'd0;
            endcase
         end
         ENT_AMP: begin
            case (idx)
               3'd0:    b = "&";
               3'd1:    b = "a";
               3'd2:    b = "m";
               3'd3:    b = "p";
               3'd4:    b = ";";
               default: b = 8'd0;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    b = "&";
               3'd1:    b = "n";
               3'd2:    b = "b";
               3'd3:    b = "s";
               3'd4:    b = "p";
               3'd5:    b = ";";
               default: b = 8'd0;
            endcase
         end
      endcase
      return b;
   endfunction

   function automatic logic [2:0] ent_len(input logic [1:0] sel);
      logic [2:0] n;
      case (sel)
         ENT_LT:  n = 3'd4;
         ENT_GT:  n = 3'd4;
         ENT_AMP: n = 3'd5;
         default: n = 3'd6;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] ent_dec(input logic [1:0] sel);
      logic [7:0] b;
      case (sel)
         ENT_LT:  b = "<";
         ENT_GT:  b = ">";
         ENT_AMP: b = "&";
         default: b = " ";
      endcase
      return b;
   endfunction

endpackage

// ===== sv/html_tag_script_stripper.sv =====
// ----------------------------------------------------------------------------
// html_tag_script_stripper
// Removes html tags and script sections from a byte stream and decodes the
// entities lt, gt, amp and nbsp.
// ----------------------------------------------------------------------------
// req_ carries one text byte per beat; rsp_ carries the filtered bytes, with
// rsp_tlast set on the final byte that one input byte releases. An input byte
// may release no byte at all (markup, held cr or partial entity) or up to
// seven (a flushed partial entity, a held cr and the byte itself).
// csr_ writes filter_enable; it is taken only while no input byte sits in
// the input register, and 0 passes every byte through unchanged.
// An accepted byte is registered in the input register and decoded there; its
// result beats are loaded into the result buffer, which drives rsp_.
// Throughput: one input byte per cycle while each byte releases at most one
// result; a byte with n results holds the result buffer until the last of
// them is taken, one beat per cycle, and the input stalls behind it only if
// it has results too. Bytes that release nothing never wait on the buffer.
// Reset clears the matchers, empties the buffers and sets filter_enable to 1.
// When rsp_tready is low the result buffer holds and, once the next byte
// with results is decoded, req_tready drops.
// ----------------------------------------------------------------------------
module html_tag_script_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_char
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   logic                                  s1_valid_ff, s1_valid_in;
   logic [7:0]                            s1_char_ff, s1_char_in;
   hts_pkg::state_type                    state_ff, state_in;
   logic                                  filter_enable_ff, filter_enable_in;
   logic [hts_pkg::MAX_OUT-1:0][7:0]      buf_bytes_ff, buf_bytes_in;
   logic [hts_pkg::COUNT_W-1:0]           buf_count_ff, buf_count_in;

   hts_pkg::state_type                    step_state;
   hts_pkg::result_type                   step_res;
   logic                                  take;
   logic                                  buf_free;
   logic                                  advance;

   hts_step u_step (
      .state_cur (state_ff),
      .filter_en (filter_enable_ff),
      .char_in   (s1_char_ff),
      .state_nxt (step_state),
      .result    (step_res)
   );

   assign take     = rsp_tvalid && rsp_tready;
   assign buf_free = (buf_count_ff == '0) ||
                     (take && buf_count_ff == hts_pkg::COUNT_W'(1));
   // bytes without results only update the matchers
   assign advance  = s1_valid_ff && ((step_res.count == '0) || buf_free);

   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = !s1_valid_ff;
   assign rsp_tvalid = (buf_count_ff != '0);
   assign rsp_tdata  = buf_bytes_ff[0];
   assign rsp_tlast  = (buf_count_ff == hts_pkg::COUNT_W'(1));

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_char_in  = s1_char_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_char_in  = req_tdata;
      end
   end

   always_comb begin
      state_in = advance ? step_state : state_ff;
   end

   always_comb begin
      filter_enable_in = (csr_valid && csr_ready) ? csr_data : filter_enable_ff;
   end

   always_comb begin
      buf_bytes_in = buf_bytes_ff;
      buf_count_in = buf_count_ff;
      if (advance && step_res.count != '0) begin
         buf_bytes_in = step_res.bytes;
         buf_count_in = step_res.count;
      end else if (take) begin
         // shift the next beat into the head slot
         for (int j = 0; j < hts_pkg::MAX_OUT - 1; j++) begin
            buf_bytes_in[j] = buf_bytes_ff[j+1];
         end
         buf_bytes_in[hts_pkg::MAX_OUT-1] = 8'd0;
         buf_count_in = buf_count_ff - hts_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         state_ff         <= hts_pkg::STATE_RESET;
         filter_enable_ff <= 1'b1;
         buf_count_ff     <= '0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         state_ff         <= state_in;
         filter_enable_ff <= filter_enable_in;
         buf_count_ff     <= buf_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_char_ff   <= s1_char_in;
      buf_bytes_ff <= buf_bytes_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      buf_count_ff <= hts_pkg::COUNT_W'(hts_pkg::MAX_OUT))
      else $error("result buffer count out of range");

   a_bypass_one: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !filter_enable_ff |-> step_res.count == hts_pkg::COUNT_W'(1))
      else $error("bypass byte must give exactly one beat");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      advance && step_res.count != '0 |=> buf_count_ff == $past(step_res.count))
      else $error("result buffer not loaded with decoded beats");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && step_res.count != '0 && !buf_free |-> !req_tready)
      else $error("input accepted while decoded beats cannot be buffered");

endmodule

// ===== sv/hts_step.sv =====
// ----------------------------------------------------------------------------
// hts_step
// Per-byte filter update: next matcher state and the list of result bytes
// that one input byte releases.
// ----------------------------------------------------------------------------
module hts_step (
   input  hts_pkg::state_type  state_cur,
   input  logic                filter_en,
   input  logic [7:0]          char_in,
   output hts_pkg::state_type  state_nxt,
   output hts_pkg::result_type result
);

   always_comb begin
      hts_pkg::state_type st;
      logic [2:0] k;
      logic [3:0] live;
      logic [3:0] done;
      logic [1:0] sel;
      logic [1:0] done_sel;
      logic [2:0] flen_full;
      logic [2:0] flen;
      logic       flush;
      logic       tail_req;
      logic [7:0] tail;
      logic       lf_path;
      logic       cr_out;
      logic       lho_mid;
      logic       hold;
      logic       tail_push;
      logic [3:0] pos;

      st       = state_cur;
      k        = state_cur.ent_cnt;
      flush    = 1'b0;
      tail_req = 1'b0;
      tail     = char_in;
      lf_path  = 1'b0;

      // lowest live candidate names the bytes that a flush gives back
      if (state_cur.ent_cand[0])      sel = hts_pkg::ENT_LT;
      else if (state_cur.ent_cand[1]) sel = hts_pkg::ENT_GT;
      else if (state_cur.ent_cand[2]) sel = hts_pkg::ENT_AMP;
      else if (state_cur.ent_cand[3]) sel = hts_pkg::ENT_NBSP;
      else                            sel = hts_pkg::ENT_LT;
      flen_full = (k < hts_pkg::ent_len(sel)) ? k : hts_pkg::ent_len(sel);

      for (int i = 0; i < 4; i++) begin
         live[i] = state_cur.ent_cand[i] && (k < hts_pkg::ent_len(2'(i)))
                   && (hts_pkg::ent_pat_byte(2'(i), k) == char_in);
         done[i] = live[i] && (({1'b0, k} + 4'd1) == {1'b0, hts_pkg::ent_len(2'(i))});
      end
      if (done[0])      done_sel = hts_pkg::ENT_LT;
      else if (done[1]) done_sel = hts_pkg::ENT_GT;
      else if (done[2]) done_sel = hts_pkg::ENT_AMP;
      else              done_sel = hts_pkg::ENT_NBSP;

      if (char_in == hts_pkg::CH_LF) begin
         lf_path      = 1'b1;
         flush        = (k != 3'd0);
         st.open_cnt  = 3'd0;
         st.close_cnt = 4'd0;
         if (flush) begin
            st.ent_cnt  = 3'd0;
            st.ent_cand = 4'hF;
         end
      end else if (state_cur.text_mode == hts_pkg::MODE_TAG) begin
         if (char_in == hts_pkg::CH_LT) begin
            st.open_cnt = 3'd1;
         end else if (state_cur.open_cnt == 3'd1 &&
                      (char_in == hts_pkg::CH_S_LO || char_in == hts_pkg::CH_S_UP)) begin
            st.upper    = (char_in == hts_pkg::CH_S_UP);
            st.open_cnt = 3'd2;
         end else if (state_cur.open_cnt >= 3'd2 && state_cur.open_cnt <= 3'd6 &&
                      hts_pkg::open_pat_byte(state_cur.upper, state_cur.open_cnt) == char_in) begin
            if (state_cur.open_cnt == 3'd6) begin
               st.text_mode = hts_pkg::MODE_SCRIPT;
               st.open_cnt  = 3'd0;
               st.close_cnt = 4'd0;
            end else begin
               st.open_cnt = state_cur.open_cnt + 3'd1;
            end
         end else begin
            st.open_cnt = 3'd0;
            if (char_in == hts_pkg::CH_GT) st.text_mode = hts_pkg::MODE_NORMAL;
         end
      end else if (state_cur.text_mode == hts_pkg::MODE_SCRIPT) begin
         if (state_cur.close_cnt == 4'd2 &&
             (char_in == hts_pkg::CH_S_LO || char_in == hts_pkg::CH_S_UP)) begin
            st.upper     = (char_in == hts_pkg::CH_S_UP);
            st.close_cnt = 4'd3;
         end else if (state_cur.close_cnt < 4'd9 && state_cur.close_cnt != 4'd2 &&
                      hts_pkg::close_pat_byte(state_cur.upper, state_cur.close_cnt)
                      == char_in) begin
            if (state_cur.close_cnt == 4'd8) begin
               st.close_cnt = 4'd0;
               st.text_mode = hts_pkg::MODE_NORMAL;
            end else begin
               st.close_cnt = state_cur.close_cnt + 4'd1;
            end
         end else begin
            st.close_cnt = (char_in == hts_pkg::CH_LT) ? 4'd1 : 4'd0;
         end
      end else if (char_in == hts_pkg::CH_LT) begin
         // a held entity stays held across the tag
         st.text_mode = hts_pkg::MODE_TAG;
         st.open_cnt  = 3'd1;
      end else if (k != 3'd0 && done != 4'd0) begin
         st.ent_cnt  = 3'd0;
         st.ent_cand = 4'hF;
         tail_req    = 1'b1;
         tail        = hts_pkg::ent_dec(done_sel);
      end else if (k != 3'd0 && live != 4'd0) begin
         st.ent_cand = live;
         st.ent_cnt  = k + 3'd1;
      end else begin
         flush = (k != 3'd0);
         st.ent_cnt  = 3'd0;
         st.ent_cand = 4'hF;
         if (char_in == hts_pkg::CH_AMP) begin
            st.ent_cnt = 3'd1;
         end else begin
            tail_req = 1'b1;
         end
      end

      flen = flush ? flen_full : 3'd0;

      if (lf_path) begin
         cr_out        = state_cur.pending_cr && (flen != 3'd0);
         lho_mid       = 1'b0;
         hold          = 1'b0;
         tail_push     = state_cur.line_out || (flen != 3'd0);
         tail          = hts_pkg::CH_LF;
         st.pending_cr = 1'b0;
         st.line_out   = 1'b0;
      end else begin
         cr_out    = state_cur.pending_cr && ((flen != 3'd0) || tail_req);
         lho_mid   = state_cur.line_out || cr_out || (flen != 3'd0);
         // a cr that would open the line waits for the next byte
         hold      = tail_req && (tail == hts_pkg::CH_CR) && !lho_mid;
         tail_push = tail_req && !hold;
         st.pending_cr = hold || (state_cur.pending_cr && !cr_out);
         st.line_out   = lho_mid || tail_push;
      end

      for (int j = 0; j < hts_pkg::MAX_OUT; j++) begin
         pos = 4'(j) - {3'b000, cr_out};
         if (cr_out && j == 0) begin
            result.bytes[j] = hts_pkg::CH_CR;
         end else if (pos < {1'b0, flen}) begin
            result.bytes[j] = hts_pkg::ent_pat_byte(sel, pos[2:0]);
         end else if (pos == {1'b0, flen}) begin
            result.bytes[j] = tail;
         end else begin
            result.bytes[j] = 8'd0;
         end
      end
      result.count = hts_pkg::COUNT_W'({3'b000, cr_out}) + hts_pkg::COUNT_W'(flen)
                     + hts_pkg::COUNT_W'({3'b000, tail_push});
      state_nxt = st;

      // bypass: byte goes out as is and the matchers keep their state
      if (!filter_en) begin
         state_nxt    = state_cur;
         result.bytes = '0;
         result.bytes[0] = char_in;
         result.count = hts_pkg::COUNT_W'(1);
      end
   end

endmodule
